@@ rtl/u8u16_pkg.sv @@
// Shared types, constants and byte-selection helpers for the UTF-8 to UTF-16BE transcoder.
`default_nettype none

package u8u16_pkg;

    // Command queue between the front end and the back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Code point limits
    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_ffff;
    localparam logic [31:0] MAX_BMP        = 32'h0000_ffff;
    localparam logic [31:0] SURR_LO        = 32'h0000_d800;
    localparam logic [31:0] SURR_HI        = 32'h0000_dfff;
    localparam logic [20:0] PLANE1_BASE    = 21'h01_0000;

    // Byte order mark and surrogate prefixes
    localparam logic [7:0] BOM_HI     = 8'hfe;
    localparam logic [7:0] BOM_LO     = 8'hff;
    localparam logic [7:0] HI_SURR_PF = 8'hd8;
    localparam logic [7:0] LO_SURR_PF = 8'hdc;

    // What the back end has to emit for one command
    typedef enum logic [1:0] {
        KIND_BOM,
        KIND_BMP,
        KIND_PAIR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [19:0] data;   // BMP: low 16 bits; pair: code point minus 0x10000
        logic        done;   // command comes from the text terminator
    } t_cmd;

    // Byte at position idx of a command's output run
    function automatic logic [7:0] cmd_byte(input t_cmd cmd, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (cmd.kind)
            KIND_BOM: b = idx[0] ? BOM_LO : BOM_HI;
            KIND_BMP: b = idx[0] ? cmd.data[7:0] : cmd.data[15:8];
            KIND_PAIR: begin
                unique case (idx)
                    2'd0: b = HI_SURR_PF | {6'b0, cmd.data[19:18]};
                    2'd1: b = cmd.data[17:10];
                    2'd2: b = LO_SURR_PF | {6'b0, cmd.data[9:8]};
                    2'd3: b = cmd.data[7:0];
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // True on the final byte of a command's run
    function automatic logic cmd_last(input t_cmd cmd, input logic [1:0] idx);
        return (cmd.kind == KIND_PAIR) ? (idx == 2'd3) : (idx == 2'd1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/u8u16_front.sv @@
// Front end: accepts UTF-8 words, keeps the code point accumulator, queues output commands.
`default_nettype none

module u8u16_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_q_full,
    output logic                  o_q_wr,
    output u8u16_pkg::t_cmd       o_q_data
);
    import u8u16_pkg::*;

    logic [31:0] r_accum, n_accum;
    logic        r_start, n_start;
    logic        accept;
    logic        is_cont;
    logic        has_cmd;
    logic [20:0] pair_v;
    t_cmd        cmd;

    assign full    = i_q_full;
    assign accept  = push && !i_q_full;
    assign is_cont = (i_in_byte[7:6] == 2'b10);
    assign pair_v  = r_accum[20:0] - PLANE1_BASE;

    // Classify the word into a command, if it causes output
    always_comb begin
        has_cmd   = 1'b0;
        cmd.kind  = KIND_BOM;
        cmd.data  = 20'h0;
        cmd.done  = (i_in_byte == 8'h00);
        if (r_start) begin
            has_cmd = 1'b1;
        end else if (!is_cont) begin
            if (r_accum > MAX_CODE_POINT) begin
                has_cmd = 1'b0;
            end else if (r_accum > MAX_BMP) begin
                has_cmd  = 1'b1;
                cmd.kind = KIND_PAIR;
                cmd.data = pair_v[19:0];
            end else if (r_accum < SURR_LO || r_accum > SURR_HI) begin
                has_cmd  = 1'b1;
                cmd.kind = KIND_BMP;
                cmd.data = {4'h0, r_accum[15:0]};
            end
        end
    end

    assign o_q_wr   = accept && has_cmd;
    assign o_q_data = cmd;

    // Advance the accumulator by one UTF-8 word
    always_comb begin
        n_accum = r_accum;
        n_start = r_start;
        if (accept) begin
            if (i_in_byte == 8'h00) begin
                n_accum = 32'h0;
                n_start = 1'b1;
            end else begin
                n_start = 1'b0;
                priority if (i_in_byte <= 8'h7f) begin
                    n_accum = {24'h0, i_in_byte};
                end else if (i_in_byte <= 8'hbf) begin
                    n_accum = {r_accum[25:0], i_in_byte[5:0]};
                end else if (i_in_byte <= 8'hdf) begin
                    n_accum = {27'h0, i_in_byte[4:0]};
                end else if (i_in_byte <= 8'hef) begin
                    n_accum = {28'h0, i_in_byte[3:0]};
                end else begin
                    n_accum = {29'h0, i_in_byte[2:0]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= 32'h0;
            r_start <= 1'b1;
        end else begin
            r_accum <= n_accum;
            r_start <= n_start;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8u16_queue.sv @@
// Short command queue that decouples the front end from the back end.
`default_nettype none

module u8u16_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire u8u16_pkg::t_cmd  i_wdata,
    input  wire logic             i_rd,
    output u8u16_pkg::t_cmd       o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    import u8u16_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                do_wr, do_rd;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = do_wr ? QUEUE_AW'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_rd ? QUEUE_AW'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = QUEUE_CW'(r_count + 1'b1);
        end else if (do_rd && !do_wr) begin
            n_count = QUEUE_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8u16_back.sv @@
// Back end: expands queued commands into UTF-16BE words behind an output register.
`default_nettype none

module u8u16_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire u8u16_pkg::t_cmd  i_q_data,
    output logic                  o_q_rd,
    input  wire logic             pop,
    output logic                  empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last,
    output logic                  o_text_done
);
    import u8u16_pkg::*;

    t_cmd        r_cmd, n_cmd;
    logic        r_busy, n_busy;
    logic [1:0]  r_idx, n_idx;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;
    logic        r_odone, n_odone;
    logic        slot_free;

    assign slot_free   = !r_ovalid || pop;
    assign empty       = !r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_run_last  = r_olast;
    assign o_text_done = r_odone;

    // One word per cycle while slot_free: continue the command or start the next
    always_comb begin
        n_cmd    = r_cmd;
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_odone  = r_odone;
        o_q_rd   = 1'b0;
        if (slot_free) begin
            if (r_busy) begin
                n_ovalid = 1'b1;
                n_obyte  = cmd_byte(r_cmd, r_idx);
                n_olast  = cmd_last(r_cmd, r_idx);
                n_odone  = r_cmd.done;
                n_idx    = r_idx + 2'd1;
                n_busy   = !cmd_last(r_cmd, r_idx);
            end else if (!i_q_empty) begin
                o_q_rd   = 1'b1;
                n_cmd    = i_q_data;
                n_ovalid = 1'b1;
                n_obyte  = cmd_byte(i_q_data, 2'd0);
                n_olast  = 1'b0;
                n_odone  = i_q_data.done;
                n_idx    = 2'd1;
                n_busy   = 1'b1;
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_odone <= n_odone;
    end

endmodule

`default_nettype wire

@@ rtl/utf8_to_utf16be_transcoder.sv @@
// Top level of the UTF-8 to UTF-16BE transcoder.
`default_nettype none

// Converts a UTF-8 word stream (a zero word ends each text) into UTF-16BE words,
// opening every text with the byte order mark FE FF. Code points above 0x10FFFF
// and surrogate values produce nothing; code points above 0xFFFF become surrogate
// pairs. Malformed sequences are not rejected: lead bytes simply reload the
// accumulator and continuation bytes shift into it. The front end takes one input
// word per cycle while the queue has room and drops a command for each word that
// causes output into a four-entry queue; the back end emits one output word per
// cycle from that queue into an output register while that register is free or
// being popped. The output side sets the rate: a word that emits a BMP code point
// or the byte order mark gives two output words, a surrogate pair four, and one
// that emits nothing (continuation bytes, dropped values) none. run_last marks
// the final output word caused by one input word; text_done marks the words
// caused by the terminator.
module utf8_to_utf16be_transcoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_text_done
);
    import u8u16_pkg::*;

    logic q_wr, q_rd, q_full, q_empty;
    t_cmd q_wdata, q_rdata;

    u8u16_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr),
        .o_q_data  (q_wdata)
    );

    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_rd      (q_rd),
        .pop         (pop),
        .empty       (empty),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

`default_nettype wire

@@ tb/tb_utf8_to_utf16be_transcoder.sv @@
// Self-checking testbench for the UTF-8 to UTF-16BE transcoder.
`default_nettype none

module tb_utf8_to_utf16be_transcoder;
    import u8u16_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } t_utf16_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       pop;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_text_done;

    // Expected UTF-16BE words, oldest first
    t_utf16_word pending_utf16_q[$];

    // Shadow copy of the decoder state
    logic [31:0] code_point_acc;
    logic        text_start;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int bytes_sent;
    int err_count;
    int quiet_cycles;

    utf8_to_utf16be_transcoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .pop        (pop),
        .empty      (empty),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_text_done(o_text_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Append one expected word to the current run
    function automatic void queue_utf16_byte(input logic [7:0] value, input logic done);
        t_utf16_word w;
        w.out_byte  = value;
        w.run_last  = 1'b0;
        w.text_done = done;
        pending_utf16_q.push_back(w);
    endfunction

    // Work out the words caused by one UTF-8 byte and advance the shadow state
    function automatic void predict_utf16_bytes(input logic [7:0] ch);
        logic        is_cont;
        logic        done;
        int          first;
        logic [31:0] cp;
        logic [31:0] v;
        is_cont = (ch[7:6] == 2'b10);
        done    = (ch == 8'h00);
        first   = pending_utf16_q.size();
        cp      = code_point_acc;

        // Open the text with a BOM, or flush the pending code point
        if (text_start) begin
            queue_utf16_byte(BOM_HI, done);
            queue_utf16_byte(BOM_LO, done);
        end else if (!is_cont && cp <= MAX_CODE_POINT) begin
            if (cp > MAX_BMP) begin
                v = cp - 32'h0001_0000;
                queue_utf16_byte(HI_SURR_PF | {6'b0, v[19:18]}, done);
                queue_utf16_byte(v[17:10], done);
                queue_utf16_byte(LO_SURR_PF | {6'b0, v[9:8]}, done);
                queue_utf16_byte(v[7:0], done);
            end else if (cp < SURR_LO || cp > SURR_HI) begin
                queue_utf16_byte(cp[15:8], done);
                queue_utf16_byte(cp[7:0], done);
            end
        end

        // Update the accumulator
        if (done) begin
            code_point_acc = 32'h0;
            text_start     = 1'b1;
        end else begin
            if (ch <= 8'h7f)
                code_point_acc = {24'h0, ch};
            else if (ch <= 8'hbf)
                code_point_acc = {code_point_acc[25:0], ch[5:0]};
            else if (ch <= 8'hdf)
                code_point_acc = {27'h0, ch[4:0]};
            else if (ch <= 8'hef)
                code_point_acc = {28'h0, ch[3:0]};
            else
                code_point_acc = {29'h0, ch[2:0]};
            text_start = 1'b0;
        end

        // Mark the final word of this run
        if (pending_utf16_q.size() > first)
            pending_utf16_q[pending_utf16_q.size() - 1].run_last = 1'b1;
    endfunction

    // Offer one byte, idling at random, and predict once it is taken
    task automatic send_byte(input logic [7:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_utf16_bytes(value);
        bytes_sent++;
    endtask

    // Encode one code point as UTF-8, up to 0x1FFFFF
    task automatic send_code_point(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            send_byte({1'b0, cp[6:0]});
        end else if (cp <= 21'h7ff) begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hffff) begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end else begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
    endtask

    // Well-formed sequence with random content, out-of-range values included
    task automatic send_random_code_point();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            send_code_point(21'($urandom_range(8'h7f, 1)));
        else if (r < 45)
            send_code_point(21'($urandom_range(12'h7ff, 8'h80)));
        else if (r < 55)
            send_code_point(21'($urandom_range(16'hffff, 12'h800)));
        else if (r < 62)
            send_code_point(21'($urandom_range(16'hdfff, 16'hd800)));
        else if (r < 88)
            send_code_point(21'($urandom_range(21'h10ffff, 21'h10000)));
        else
            send_code_point(21'($urandom_range(21'h1fffff, 21'h110000)));
    endtask

    // Mostly well-formed text, some terminators, noise and broken sequences
    task automatic send_random_bytes(input int count);
        int stop_at;
        int r;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 65) begin
                send_random_code_point();
            end else if (r < 78) begin
                send_byte(8'h00);
            end else if (r < 92) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(8'($urandom_range(8'hff, 8'hc0)));
                repeat ($urandom_range(5))
                    send_byte({2'b10, 6'($urandom_range(63))});
            end
        end
    endtask

    // Lower push after the last byte
    task automatic stop_sending();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        // Empty text: BOM only, closed by the terminator
        seq = {8'h00};
        // Continuation at text start, the top ASCII value, the widest 2/3-byte values
        seq = {seq, 8'h80, 8'h7f, 8'hdf, 8'hbf, 8'hef, 8'hbf, 8'hbf};
        // Surrogate value, first and last supplementary values
        seq = {seq, 8'hed, 8'ha0, 8'h80, 8'hf0, 8'h90, 8'h80, 8'h80};
        seq = {seq, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        // Just above the Unicode range, then a terminator that only drops it
        seq = {seq, 8'hf4, 8'h90, 8'h80, 8'h80, 8'h00};
        // Top lead byte with continuations shifted past 32 bits
        seq = {seq, 8'hff, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'h01, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_random_text(input int count);
        send_random_bytes(count);
    endtask

    // Hold the receiver while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        hold_left = HOLD_CYCLES;
        send_random_bytes(35);
    endtask

    // Receiver: idle at random, or hold off for a long stretch on request
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_utf16_word w;
        if (i_rst_n && pop && !empty) begin
            if (pending_utf16_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual byte %h last %b done %b",
                         $time, o_out_byte, o_run_last, o_text_done);
                err_count++;
            end else begin
                w = pending_utf16_q.pop_front();
                if (o_out_byte !== w.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, w.out_byte, o_out_byte);
                    err_count++;
                end
                if (o_run_last !== w.run_last) begin
                    $display("%0t: run_last mismatch: expected %b, actual %b",
                             $time, w.run_last, o_run_last);
                    err_count++;
                end
                if (o_text_done !== w.text_done) begin
                    $display("%0t: text_done mismatch: expected %b, actual %b",
                             $time, w.text_done, o_text_done);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        push           = 1'b0;
        i_in_byte      = 8'h00;
        i_rst_n        = 1'b0;
        code_point_acc = 32'h0;
        text_start     = 1'b1;
        send_idle_pct  = 28;
        recv_idle_pct  = 57;
        hold_left      = 0;
        bytes_sent     = 0;
        err_count      = 0;
        quiet_cycles   = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_text(45);

        send_idle_pct = 57;
        recv_idle_pct = 28;
        test_random_text(45);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_text(40);
        stop_sending();

        // Drain, then give the block time to show any extra word
        while (pending_utf16_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16be_transcoder.sv
tb/tb_utf8_to_utf16be_transcoder.sv
